// ===== hw/rtl/cthg_pkg.sv =====
// cthg_pkg: shared types and constants of the 3x3 gray high-pass convolution block
// used by every module of the block, depends on nothing
`default_nettype none

package cthg_pkg;

   localparam int PIX_W       = 8;
   localparam int RGB_SUM_W   = 10;
   localparam int GRAY_PROD_W = 20;
   localparam int GRAY_RECIP  = 683;   // ceil(2048 / 3)
   localparam int GRAY_SHIFT  = 11;
   localparam int DIM_W       = 11;
   localparam int COORD_W     = 10;
   localparam int CSR_W       = 48;
   localparam int CSR_IDX_W   = 3;
   localparam int SLOT_W      = 16;
   localparam int TAPS        = 3;
   localparam int SUM_W       = 28;
   localparam int ACC_W       = 29;
   localparam int PIX_MAX     = 255;
   localparam int RES_DEPTH   = 8;

   localparam logic [DIM_W-1:0] FRAME_WIDTH_RESET  = 11'd4;
   localparam logic [DIM_W-1:0] FRAME_HEIGHT_RESET = 11'd4;
   localparam logic [CSR_W-1:0] KERNEL_EDGE_RESET  = 48'd4293656576;
   localparam logic [CSR_W-1:0] KERNEL_MID_RESET   = 48'd281389082673132;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FRAME_WIDTH   = 3'd0,
      CSR_FRAME_HEIGHT  = 3'd1,
      CSR_KERNEL_TOP    = 3'd2,
      CSR_KERNEL_MIDDLE = 3'd3,
      CSR_KERNEL_BOTTOM = 3'd4
   } cthg_csr_type;

   typedef enum logic {
      FUNC_PIXEL = 1'b0,
      FUNC_DRAIN = 1'b1
   } cthg_func_type;

   // what travels with an item down the convolution pipeline
   typedef struct packed {
      logic               emit_a;
      logic               emit_b;
      logic               last_b;
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] col_a;
      logic [COORD_W-1:0] col_b;
   } cthg_tag_type;

   // new window column: top, middle and bottom pixel
   typedef struct packed {
      logic             pos_zero;
      logic [PIX_W-1:0] top;
      logic [PIX_W-1:0] mid;
      logic [PIX_W-1:0] bot;
   } cthg_column_type;

   typedef struct packed {
      logic [PIX_W-1:0]   pixel;
      logic [SUM_W-1:0]   raw_sum;
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] column;
      logic               last;
   } cthg_result_type;

endpackage

`default_nettype wire

// ===== hw/rtl/cthg_line_store.sv =====
// cthg_line_store: the two gray line memories with read-modify-write and forwarding
// uses cthg_pkg for pixel width
`default_nettype none

module cthg_line_store #(
   parameter int MAX_WIDTH = 1024
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          rd_en,
   input  wire                          rd_fill,
   input  wire  [$clog2(MAX_WIDTH)-1:0] rd_pos,
   input  wire                          wr_en,
   input  wire  [$clog2(MAX_WIDTH)-1:0] wr_pos,
   input  wire  [cthg_pkg::PIX_W-1:0]   wr_gray,
   output logic [cthg_pkg::PIX_W-1:0]   older_q,
   output logic [cthg_pkg::PIX_W-1:0]   newer_q
);

   localparam int POS_W  = $clog2(MAX_WIDTH);
   localparam int FILL_W = $clog2(MAX_WIDTH + 1);

   logic [cthg_pkg::PIX_W-1:0] older_mem [MAX_WIDTH];
   logic [cthg_pkg::PIX_W-1:0] newer_mem [MAX_WIDTH];

   logic [cthg_pkg::PIX_W-1:0] older_rd_ff, newer_rd_ff;
   logic [cthg_pkg::PIX_W-1:0] fwd_old_ff, fwd_new_ff;
   logic                       fwd_ff, known_ff;
   logic [FILL_W-1:0]          fill_ff, fill_in;

   // entries are only ever written from position zero upward, so the written
   // ones form a prefix below the fill mark and the rest still read as zero
   always_comb begin
      fill_in = fill_ff;
      if (rd_en && rd_fill && (FILL_W'(rd_pos) == fill_ff)) begin
         fill_in = fill_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         fwd_ff  <= 1'b0;
      end else begin
         fill_ff <= fill_in;
         if (rd_en) begin
            fwd_ff <= wr_en && (wr_pos == rd_pos);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         older_rd_ff <= older_mem[rd_pos];
         newer_rd_ff <= newer_mem[rd_pos];
         known_ff    <= FILL_W'(rd_pos) < fill_ff;
         fwd_old_ff  <= newer_q;
         fwd_new_ff  <= wr_gray;
      end
      if (wr_en) begin
         older_mem[wr_pos] <= newer_q;
         newer_mem[wr_pos] <= wr_gray;
      end
   end

   // the write of the previous item lands on the same edge as this read
   always_comb begin
      if (fwd_ff) begin
         older_q = fwd_old_ff;
         newer_q = fwd_new_ff;
      end else if (known_ff) begin
         older_q = older_rd_ff;
         newer_q = newer_rd_ff;
      end else begin
         older_q = '0;
         newer_q = '0;
      end
   end

   a_write_below_fill: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (FILL_W'(wr_pos) < fill_ff))
      else $error("line store written above its fill mark");

endmodule

`default_nettype wire

// ===== hw/rtl/cthg_window_mac.sv =====
// cthg_window_mac: 3x3 window columns, nine products for result a, six for result b, sums and clamp
// uses cthg_pkg for the column, tag and result types
`default_nettype none

module cthg_window_mac #(
   parameter int COEF_BITS = 16
) (
   input  wire                                                clock,
   input  wire                                                reset,
   input  wire                                                col_valid,
   input  wire  cthg_pkg::cthg_column_type                    col,
   input  wire  cthg_pkg::cthg_tag_type                       tag,
   input  wire  [cthg_pkg::TAPS-1:0][cthg_pkg::CSR_W-1:0]     kernel,
   output logic                                               push_a,
   output logic                                               push_b,
   output cthg_pkg::cthg_result_type                          res_a,
   output cthg_pkg::cthg_result_type                          res_b
);

   localparam int PROD_W = COEF_BITS + cthg_pkg::PIX_W + 1;
   localparam int ACC_W  = cthg_pkg::ACC_W;

   function automatic logic signed [PROD_W-1:0] mul_tap(
      input logic signed [COEF_BITS-1:0] c,
      input logic [cthg_pkg::PIX_W-1:0]  p
   );
      logic signed [PROD_W-1:0] ce, pe;
      ce = PROD_W'(c);
      pe = $signed(PROD_W'(p));
      return ce * pe;
   endfunction

   function automatic cthg_pkg::cthg_result_type make_result(
      input logic signed [ACC_W-1:0]       total,
      input logic [cthg_pkg::COORD_W-1:0]  row,
      input logic [cthg_pkg::COORD_W-1:0]  column,
      input logic                          last
   );
      cthg_pkg::cthg_result_type r;
      if (total < 0) begin
         r.pixel = '0;
      end else if (total > ACC_W'(cthg_pkg::PIX_MAX)) begin
         r.pixel = cthg_pkg::PIX_W'(cthg_pkg::PIX_MAX);
      end else begin
         r.pixel = total[cthg_pkg::PIX_W-1:0];
      end
      r.raw_sum = total[cthg_pkg::SUM_W-1:0];
      r.row     = row;
      r.column  = column;
      r.last    = last;
      return r;
   endfunction

   // two older columns of the window, one entry per kernel row
   logic [cthg_pkg::PIX_W-1:0] c1_ff [cthg_pkg::TAPS];
   logic [cthg_pkg::PIX_W-1:0] c2_ff [cthg_pkg::TAPS];
   logic [cthg_pkg::PIX_W-1:0] win_l [cthg_pkg::TAPS];
   logic [cthg_pkg::PIX_W-1:0] win_m [cthg_pkg::TAPS];
   logic [cthg_pkg::PIX_W-1:0] win_n [cthg_pkg::TAPS];

   logic signed [COEF_BITS-1:0] coef   [cthg_pkg::TAPS][cthg_pkg::TAPS];
   logic signed [PROD_W-1:0]    prod_a [cthg_pkg::TAPS][cthg_pkg::TAPS];
   logic signed [PROD_W-1:0]    prod_b [cthg_pkg::TAPS][2];

   logic                        s2_valid_ff;
   cthg_pkg::cthg_tag_type      s2_tag_ff;
   logic signed [PROD_W-1:0]    s2_pa_ff [cthg_pkg::TAPS][cthg_pkg::TAPS];
   logic signed [PROD_W-1:0]    s2_pb_ff [cthg_pkg::TAPS][2];

   logic signed [ACC_W-1:0]     row_a [cthg_pkg::TAPS];
   logic signed [ACC_W-1:0]     row_b [cthg_pkg::TAPS];

   logic                        s3_valid_ff;
   cthg_pkg::cthg_tag_type      s3_tag_ff;
   logic signed [ACC_W-1:0]     s3_ra_ff [cthg_pkg::TAPS];
   logic signed [ACC_W-1:0]     s3_rb_ff [cthg_pkg::TAPS];

   logic signed [ACC_W-1:0]     total_a, total_b;

   always_comb begin
      for (int r = 0; r < cthg_pkg::TAPS; r++) begin
         for (int k = 0; k < cthg_pkg::TAPS; k++) begin
            coef[r][k] = $signed(kernel[r][cthg_pkg::SLOT_W*k +: COEF_BITS]);
         end
      end
   end

   // window after the shift: left, middle, new right column
   always_comb begin
      win_n[0] = col.top;
      win_n[1] = col.mid;
      win_n[2] = col.bot;
      for (int r = 0; r < cthg_pkg::TAPS; r++) begin
         win_l[r] = col.pos_zero ? '0 : c1_ff[r];
         win_m[r] = col.pos_zero ? '0 : c2_ff[r];
      end
   end

   // second result at the row end sees the window shifted once more
   always_comb begin
      for (int r = 0; r < cthg_pkg::TAPS; r++) begin
         prod_a[r][0] = mul_tap(coef[r][0], win_l[r]);
         prod_a[r][1] = mul_tap(coef[r][1], win_m[r]);
         prod_a[r][2] = mul_tap(coef[r][2], win_n[r]);
         prod_b[r][0] = mul_tap(coef[r][0], win_m[r]);
         prod_b[r][1] = mul_tap(coef[r][1], win_n[r]);
      end
   end

   always_ff @(posedge clock) begin
      if (col_valid) begin
         for (int r = 0; r < cthg_pkg::TAPS; r++) begin
            c1_ff[r] <= win_m[r];
            c2_ff[r] <= win_n[r];
         end
      end
      s2_tag_ff <= tag;
      s2_pa_ff  <= prod_a;
      s2_pb_ff  <= prod_b;
   end

   always_comb begin
      for (int r = 0; r < cthg_pkg::TAPS; r++) begin
         row_a[r] = ACC_W'(s2_pa_ff[r][0]) + ACC_W'(s2_pa_ff[r][1])
                  + ACC_W'(s2_pa_ff[r][2]);
         row_b[r] = ACC_W'(s2_pb_ff[r][0]) + ACC_W'(s2_pb_ff[r][1]);
      end
   end

   always_ff @(posedge clock) begin
      s3_tag_ff <= s2_tag_ff;
      s3_ra_ff  <= row_a;
      s3_rb_ff  <= row_b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= col_valid;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_comb begin
      total_a = s3_ra_ff[0] + s3_ra_ff[1] + s3_ra_ff[2];
      total_b = s3_rb_ff[0] + s3_rb_ff[1] + s3_rb_ff[2];
      push_a  = s3_valid_ff && s3_tag_ff.emit_a;
      push_b  = s3_valid_ff && s3_tag_ff.emit_b;
      res_a   = make_result(total_a, s3_tag_ff.row, s3_tag_ff.col_a, 1'b0);
      res_b   = make_result(total_b, s3_tag_ff.row, s3_tag_ff.col_b, s3_tag_ff.last_b);
   end

endmodule

`default_nettype wire

// ===== hw/rtl/cthg_out_fifo.sv =====
// cthg_out_fifo: result queue, takes up to two items a cycle and gives one
// uses cthg_pkg for the result type and queue depth
`default_nettype none

module cthg_out_fifo (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        push_a,
   input  wire                        push_b,
   input  wire  cthg_pkg::cthg_result_type res_a,
   input  wire  cthg_pkg::cthg_result_type res_b,
   input  wire                        pop,
   output logic                       head_valid,
   output cthg_pkg::cthg_result_type  head
);

   localparam int DEPTH = cthg_pkg::RES_DEPTH;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   cthg_pkg::cthg_result_type entry_ff [DEPTH];

   logic [PTR_W-1:0] wp_ff, rp_ff, wp_b;
   logic [CNT_W-1:0] count_ff, count_in;

   assign wp_b       = wp_ff + PTR_W'(push_a);
   assign head_valid = count_ff != '0;
   assign head       = entry_ff[rp_ff];
   assign count_in   = count_ff + CNT_W'(push_a) + CNT_W'(push_b) - CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (push_a) begin
         entry_ff[wp_ff] <= res_a;
      end
      if (push_b) begin
         entry_ff[wp_b] <= res_b;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff    <= '0;
         rp_ff    <= '0;
         count_ff <= '0;
      end else begin
         wp_ff    <= wp_ff + PTR_W'(push_a) + PTR_W'(push_b);
         rp_ff    <= rp_ff + PTR_W'(pop);
         count_ff <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (32'(count_ff) + 32'(push_a) + 32'(push_b)) <= DEPTH)
      else $error("result queue overflow");

endmodule

`default_nettype wire

// ===== hw/rtl/conv3x3_highpass_gray.sv =====
// conv3x3_highpass_gray: RGB to gray, 3x3 zero-border convolution, clamp to 0..255
// depends on cthg_pkg, cthg_line_store, cthg_window_mac, cthg_out_fifo
//
//   channel | ports                              | direction | handshake
//   req     | req_func, req_red/green/blue       | in        | req_valid / req_stall
//   rsp     | rsp_filtered_pixel .. frame_last   | out       | rsp_valid / rsp_stall
//   csr     | csr_index, csr_write_data          | in        | csr_write_enable
//
// one item a cycle while req_stall is low; an item at the last column of a row
// gives two results, which leave one a cycle while rsp_stall is low through an
// 8-entry result queue that sets the input stall. rsp_valid follows acceptance
// through the line memory read, then the product, row sum and queue registers.
// synchronous active-high reset; line memories need no clearing pass, a fill mark
// makes entries never written read as zero, so items are taken right after reset.
`default_nettype none

module conv3x3_highpass_gray #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024,
   parameter int COEF_BITS  = 16
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_valid,
   output logic                                req_stall,
   input  wire                                 req_func,
   input  wire  [cthg_pkg::PIX_W-1:0]          req_red,
   input  wire  [cthg_pkg::PIX_W-1:0]          req_green,
   input  wire  [cthg_pkg::PIX_W-1:0]          req_blue,
   output logic                                rsp_valid,
   input  wire                                 rsp_stall,
   output logic [cthg_pkg::PIX_W-1:0]          rsp_filtered_pixel,
   output logic signed [cthg_pkg::SUM_W-1:0]   rsp_raw_sum,
   output logic [cthg_pkg::COORD_W-1:0]        rsp_out_row,
   output logic [cthg_pkg::COORD_W-1:0]        rsp_out_column,
   output logic                                rsp_frame_last,
   input  wire                                 csr_write_enable,
   input  wire  [cthg_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire  [cthg_pkg::CSR_W-1:0]          csr_write_data
);

   localparam int POS_W = $clog2(MAX_WIDTH);
   localparam int ROW_W = $clog2(MAX_HEIGHT + 1);
   localparam int RES_W = $clog2(cthg_pkg::RES_DEPTH + 1);

   // configuration
   logic [cthg_pkg::DIM_W-1:0]                   fw_ff, fh_ff;
   logic [cthg_pkg::TAPS-1:0][cthg_pkg::CSR_W-1:0] kern_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fw_ff      <= cthg_pkg::FRAME_WIDTH_RESET;
         fh_ff      <= cthg_pkg::FRAME_HEIGHT_RESET;
         kern_ff[0] <= cthg_pkg::KERNEL_EDGE_RESET;
         kern_ff[1] <= cthg_pkg::KERNEL_MID_RESET;
         kern_ff[2] <= cthg_pkg::KERNEL_EDGE_RESET;
      end else if (csr_write_enable) begin
         case (cthg_pkg::cthg_csr_type'(csr_index))
            cthg_pkg::CSR_FRAME_WIDTH:   fw_ff      <= csr_write_data[cthg_pkg::DIM_W-1:0];
            cthg_pkg::CSR_FRAME_HEIGHT:  fh_ff      <= csr_write_data[cthg_pkg::DIM_W-1:0];
            cthg_pkg::CSR_KERNEL_TOP:    kern_ff[0] <= csr_write_data;
            cthg_pkg::CSR_KERNEL_MIDDLE: kern_ff[1] <= csr_write_data;
            cthg_pkg::CSR_KERNEL_BOTTOM: kern_ff[2] <= csr_write_data;
            default: ;
         endcase
      end
   end

   // effective frame size
   logic [POS_W-1:0] w_last;
   logic [ROW_W-1:0] h_eff;

   always_comb begin
      if (fw_ff == '0) begin
         w_last = '0;
      end else if (32'(fw_ff) > MAX_WIDTH) begin
         w_last = POS_W'(MAX_WIDTH - 1);
      end else begin
         w_last = POS_W'(fw_ff - 1'b1);
      end
      if (fh_ff == '0) begin
         h_eff = ROW_W'(1);
      end else if (32'(fh_ff) > MAX_HEIGHT) begin
         h_eff = ROW_W'(MAX_HEIGHT);
      end else begin
         h_eff = ROW_W'(fh_ff);
      end
   end

   // position counters and item decode
   logic [POS_W-1:0] col_ff, col_in, drain_ff, drain_in, pos;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [RES_W-1:0] res_ff, res_in;
   logic             req_accept, is_pixel, act, at_end, ge1, ge2, pop;
   logic             emit_a, emit_b;
   logic [cthg_pkg::RGB_SUM_W-1:0]   rgb_sum;
   logic [cthg_pkg::GRAY_PROD_W-1:0] gray_prod;
   logic [cthg_pkg::PIX_W-1:0]       gray;
   cthg_pkg::cthg_tag_type           tag;

   assign req_stall  = res_ff > RES_W'(cthg_pkg::RES_DEPTH - 2);
   assign req_accept = req_valid && !req_stall;
   assign pop        = rsp_valid && !rsp_stall;

   always_comb begin
      is_pixel = req_func == cthg_pkg::FUNC_PIXEL;
      act      = is_pixel ? (row_ff < h_eff) : (row_ff >= h_eff);
      pos      = is_pixel ? col_ff : drain_ff;
      at_end   = pos >= w_last;
      ge1      = row_ff != '0;
      ge2      = 32'(row_ff) >= 2;
      emit_a   = act && ge1 && (pos != '0);
      emit_b   = act && ge1 && at_end;

      // divide by three through a reciprocal, exact for sums up to 765
      rgb_sum   = cthg_pkg::RGB_SUM_W'(req_red) + cthg_pkg::RGB_SUM_W'(req_green)
                + cthg_pkg::RGB_SUM_W'(req_blue);
      gray_prod = cthg_pkg::GRAY_PROD_W'(rgb_sum)
                * cthg_pkg::GRAY_PROD_W'(cthg_pkg::GRAY_RECIP);
      gray      = is_pixel ? gray_prod[cthg_pkg::GRAY_SHIFT +: cthg_pkg::PIX_W] : '0;

      tag.emit_a = emit_a;
      tag.emit_b = emit_b;
      tag.last_b = !is_pixel && at_end;
      tag.row    = cthg_pkg::COORD_W'(row_ff - 1'b1);
      tag.col_a  = cthg_pkg::COORD_W'(pos - 1'b1);
      tag.col_b  = cthg_pkg::COORD_W'(pos);

      col_in   = col_ff;
      row_in   = row_ff;
      drain_in = drain_ff;
      if (req_accept && act) begin
         if (is_pixel) begin
            if (at_end) begin
               col_in = '0;
               row_in = row_ff + 1'b1;
            end else begin
               col_in = col_ff + 1'b1;
            end
         end else if (at_end) begin
            col_in   = '0;
            row_in   = '0;
            drain_in = '0;
         end else begin
            drain_in = drain_ff + 1'b1;
         end
      end

      res_in = res_ff - RES_W'(pop);
      if (req_accept) begin
         res_in = res_in + RES_W'(emit_a) + RES_W'(emit_b);
      end
   end

   // stage one: line memory read in flight
   logic                       s1_valid_ff, s1_pixel_ff, s1_ge1_ff, s1_ge2_ff;
   logic [POS_W-1:0]           s1_pos_ff;
   logic [cthg_pkg::PIX_W-1:0] s1_gray_ff;
   cthg_pkg::cthg_tag_type     s1_tag_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         drain_ff    <= '0;
         res_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         drain_ff    <= drain_in;
         res_ff      <= res_in;
         s1_valid_ff <= req_accept && act;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_pixel_ff <= is_pixel;
         s1_ge1_ff   <= ge1;
         s1_ge2_ff   <= ge2;
         s1_pos_ff   <= pos;
         s1_gray_ff  <= gray;
         s1_tag_ff   <= tag;
      end
   end

   logic [cthg_pkg::PIX_W-1:0] older_q, newer_q;
   cthg_pkg::cthg_column_type  column;

   cthg_line_store #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_line_store (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (req_accept && act),
      .rd_fill (is_pixel),
      .rd_pos  (pos),
      .wr_en   (s1_valid_ff && s1_pixel_ff),
      .wr_pos  (s1_pos_ff),
      .wr_gray (s1_gray_ff),
      .older_q (older_q),
      .newer_q (newer_q)
   );

   // rows above the frame read as zero border
   always_comb begin
      column.pos_zero = s1_pos_ff == '0;
      column.top      = s1_ge2_ff ? older_q : '0;
      column.mid      = s1_ge1_ff ? newer_q : '0;
      column.bot      = s1_gray_ff;
   end

   logic                      push_a, push_b;
   cthg_pkg::cthg_result_type res_a, res_b, head;

   cthg_window_mac #(
      .COEF_BITS (COEF_BITS)
   ) u_window_mac (
      .clock     (clock),
      .reset     (reset),
      .col_valid (s1_valid_ff),
      .col       (column),
      .tag       (s1_tag_ff),
      .kernel    (kern_ff),
      .push_a    (push_a),
      .push_b    (push_b),
      .res_a     (res_a),
      .res_b     (res_b)
   );

   cthg_out_fifo u_out_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_a     (push_a),
      .push_b     (push_b),
      .res_a      (res_a),
      .res_b      (res_b),
      .pop        (pop),
      .head_valid (rsp_valid),
      .head       (head)
   );

   assign rsp_filtered_pixel = head.pixel;
   assign rsp_raw_sum        = $signed(head.raw_sum);
   assign rsp_out_row        = head.row;
   assign rsp_out_column     = head.column;
   assign rsp_frame_last     = head.last;

   a_credit_covers_queue: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (res_ff != '0))
      else $error("queued item without a reserved slot");

   a_credit_bound: assert property (@(posedge clock) disable iff (reset)
      32'(res_ff) <= cthg_pkg::RES_DEPTH)
      else $error("more results reserved than queue entries");

   a_frame_end_clears: assert property (@(posedge clock) disable iff (reset)
      (req_accept && act && !is_pixel && at_end)
         |=> (row_ff == '0 && col_ff == '0 && drain_ff == '0))
      else $error("counters not cleared at frame end");

endmodule

`default_nettype wire
